// ----- rtl/core/dxt_alpha_classifier_defines.svh -----
// Assertion macros used by the alpha classifier merging stage.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef DXT_ALPHA_CLASSIFIER_DEFINES_SVH
`define DXT_ALPHA_CLASSIFIER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DXTAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DXTAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dxtac_pkg.sv -----
// Shared types, codes and constants of the alpha classifier.
// Depends on nothing; every other file of the block but the macro header refers to it.
package dxtac_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int BLK_W       = 64;
  localparam int LANES       = 16;
  localparam int CNT_W       = $clog2(LANES + 1);
  localparam int TALLY_W     = 25;
  localparam int DIM_CFG_W   = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int REG_IDX_W   = 3;
  localparam int PCT_W       = 7;
  localparam int PROD_W      = TALLY_W + PCT_W;
  localparam int PCT_SCALE   = 100;

  localparam int SUM_W       = 11;
  localparam int RECIP_W     = 12;
  localparam int DIV7_MUL    = 2341;
  localparam int DIV5_MUL    = 3277;
  localparam int DIV_SHIFT   = 14;

  localparam logic [REG_IDX_W-1:0] REG_FORMAT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_LOW  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_HIGH = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_KEYED_PCT = 3'd5;

  typedef enum logic [1:0] {
    FMT_DXT1 = 2'd0,
    FMT_DXT3 = 2'd1,
    FMT_DXT5 = 2'd2,
    FMT_NONE = 2'd3
  } fmt_t;

  typedef enum logic [1:0] {
    KIND_OPAQUE = 2'd0,
    KIND_KEYED  = 2'd1,
    KIND_GRADED = 2'd2
  } kind_t;

  typedef logic [7:0] alpha_t;

  typedef struct packed {
    logic trans;
    logic betw;
  } lane_flags_t;

  typedef struct packed {
    logic valid;
    logic sup;
    logic last;
  } beat_ctl_t;

endpackage

// ----- rtl/core/dxtac_palette.sv -----
// Two-stage DXT5 alpha palette builder: weighted sums, then division by seven
// or five through reciprocal multiplication. Depends on dxtac_pkg.
module dxtac_palette (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        ends_i,
  output dxtac_pkg::alpha_t  pal_o [8]
);

  localparam int SUM_W = dxtac_pkg::SUM_W;
  localparam int PW    = dxtac_pkg::SUM_W + dxtac_pkg::RECIP_W;

  logic [7:0]       a0_r, a1_r;
  logic             gt_r;
  logic [SUM_W-1:0] sum_nxt [6];
  logic [SUM_W-1:0] sum_r   [6];
  dxtac_pkg::alpha_t pal_nxt [8];
  dxtac_pkg::alpha_t pal_r   [8];

  always_comb begin
    logic [7:0] a0, a1;
    a0 = ends_i[7:0];
    a1 = ends_i[15:8];
    for (int i = 0; i < 6; i++) begin
      if (a0 > a1) begin
        sum_nxt[i] = SUM_W'((6 - i) * a0 + (i + 1) * a1);
      end else if (i < 4) begin
        sum_nxt[i] = SUM_W'((4 - i) * a0 + (i + 1) * a1);
      end else begin
        sum_nxt[i] = '0;
      end
    end
  end

  always_comb begin
    logic [PW-1:0] p7, p5;
    pal_nxt[0] = a0_r;
    pal_nxt[1] = a1_r;
    for (int i = 0; i < 6; i++) begin
      p7 = PW'(sum_r[i]) * PW'(dxtac_pkg::DIV7_MUL);
      p5 = PW'(sum_r[i]) * PW'(dxtac_pkg::DIV5_MUL);
      if (gt_r) begin
        pal_nxt[i+2] = p7[dxtac_pkg::DIV_SHIFT +: 8];
      end else if (i == 4) begin
        pal_nxt[i+2] = 8'h00;
      end else if (i == 5) begin
        pal_nxt[i+2] = 8'hFF;
      end else begin
        pal_nxt[i+2] = p5[dxtac_pkg::DIV_SHIFT +: 8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a0_r  <= ends_i[7:0];
      a1_r  <= ends_i[15:8];
      gt_r  <= ends_i[7:0] > ends_i[15:8];
      sum_r <= sum_nxt;
      pal_r <= pal_nxt;
    end
  end

  assign pal_o = pal_r;

endmodule

// ----- rtl/core/dxtac_lane.sv -----
// One texel lane: decodes a texel alpha for the selected format and sorts it
// against the low and high edges. Depends on dxtac_pkg.
module dxtac_lane (
  input  dxtac_pkg::fmt_t        fmt_i,
  input  logic [1:0]             code1_i,
  input  logic [3:0]             code3_i,
  input  logic [2:0]             code5_i,
  input  logic                   c_gt_i,
  input  dxtac_pkg::alpha_t      pal_i [8],
  input  logic [7:0]             edge_low_i,
  input  logic [7:0]             edge_high_i,
  output dxtac_pkg::lane_flags_t flags_o
);

  dxtac_pkg::alpha_t alpha;

  always_comb begin
    unique case (fmt_i)
      dxtac_pkg::FMT_DXT1: alpha = (!c_gt_i && code1_i == 2'd3) ? 8'h00 : 8'hFF;
      dxtac_pkg::FMT_DXT3: alpha = {code3_i, code3_i};
      dxtac_pkg::FMT_DXT5: alpha = pal_i[code5_i];
      default:             alpha = 8'h00;
    endcase
  end

  assign flags_o.trans = alpha <= edge_low_i;
  assign flags_o.betw  = (alpha > edge_low_i) && (alpha < edge_high_i);

endmodule

// ----- rtl/core/dxtac_merge.sv -----
// Merging stage: counts lane flags, keeps the surface tallies, forms the
// percentage test and holds the result register. Depends on dxtac_pkg.
`include "dxt_alpha_classifier_defines.svh"

module dxtac_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dxtac_pkg::beat_ctl_t         ctl_i,
  input  logic [dxtac_pkg::LANES-1:0]  vis_i,
  input  logic [dxtac_pkg::LANES-1:0]  trans_i,
  input  logic [dxtac_pkg::LANES-1:0]  betw_i,
  input  logic [dxtac_pkg::PCT_W-1:0]  keyed_pct_i,
  input  logic                         out_stall,
  output logic                         adv_o,
  output logic                         out_valid,
  output logic [1:0]                   out_alpha_kind,
  output logic [dxtac_pkg::TALLY_W-1:0] out_texel_total,
  output logic [dxtac_pkg::TALLY_W-1:0] out_between_count,
  output logic [dxtac_pkg::TALLY_W-1:0] out_transparent_count
);

  localparam int LANES   = dxtac_pkg::LANES;
  localparam int CNT_W   = dxtac_pkg::CNT_W;
  localparam int TALLY_W = dxtac_pkg::TALLY_W;
  localparam int PROD_W  = dxtac_pkg::PROD_W;

  function automatic logic [CNT_W-1:0] popcnt(input logic [LANES-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < LANES; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

  logic [TALLY_W-1:0] tally_t_r, tally_b_r, tally_x_r;
  logic [TALLY_W-1:0] tally_t_nxt, tally_b_nxt, tally_x_nxt;

  logic               m1_v_r, m1_sup_r;
  logic [TALLY_W-1:0] m1_t_r, m1_b_r, m1_x_r;

  logic               m2_v_r, m2_sup_r, m2_zero_r;
  logic [TALLY_W-1:0] m2_t_r, m2_b_r, m2_x_r;
  logic [PROD_W-1:0]  m2_b100_r, m2_tk_r;

  logic               out_valid_r;
  dxtac_pkg::kind_t   out_kind_r;
  logic [TALLY_W-1:0] out_t_r, out_b_r, out_x_r;
  dxtac_pkg::kind_t   kind_nxt;
  logic               out_load;
  logic               adv;

  assign adv      = !(out_valid_r && out_stall && m2_v_r);
  assign out_load = !out_valid_r || !out_stall;

  assign tally_t_nxt = tally_t_r + TALLY_W'(popcnt(vis_i));
  assign tally_b_nxt = tally_b_r + TALLY_W'(popcnt(betw_i));
  assign tally_x_nxt = tally_x_r + TALLY_W'(popcnt(trans_i));

  always_comb begin
    if (!m2_sup_r) begin
      kind_nxt = dxtac_pkg::KIND_GRADED;
    end else if (m2_zero_r) begin
      kind_nxt = dxtac_pkg::KIND_OPAQUE;
    end else if (m2_b100_r < m2_tk_r) begin
      kind_nxt = dxtac_pkg::KIND_KEYED;
    end else begin
      kind_nxt = dxtac_pkg::KIND_GRADED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_t_r   <= '0;
      tally_b_r   <= '0;
      tally_x_r   <= '0;
      m1_v_r      <= 1'b0;
      m2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        m1_v_r <= ctl_i.valid && ctl_i.last;
        m2_v_r <= m1_v_r;
        if (ctl_i.valid) begin
          if (ctl_i.last) begin
            tally_t_r <= '0;
            tally_b_r <= '0;
            tally_x_r <= '0;
          end else begin
            tally_t_r <= tally_t_nxt;
            tally_b_r <= tally_b_nxt;
            tally_x_r <= tally_x_nxt;
          end
        end
      end
      if (out_load) begin
        out_valid_r <= m2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_sup_r  <= ctl_i.sup;
      m1_t_r    <= tally_t_nxt;
      m1_b_r    <= tally_b_nxt;
      m1_x_r    <= tally_x_nxt;
      m2_sup_r  <= m1_sup_r;
      m2_zero_r <= (m1_b_r == '0) && (m1_x_r == '0);
      m2_t_r    <= m1_t_r;
      m2_b_r    <= m1_b_r;
      m2_x_r    <= m1_x_r;
      m2_b100_r <= PROD_W'(m1_b_r) * PROD_W'(dxtac_pkg::PCT_SCALE);
      m2_tk_r   <= PROD_W'(m1_t_r) * PROD_W'(keyed_pct_i);
    end
    if (out_load) begin
      out_kind_r <= kind_nxt;
      out_t_r    <= m2_sup_r ? m2_t_r : '0;
      out_b_r    <= m2_sup_r ? m2_b_r : '0;
      out_x_r    <= m2_sup_r ? m2_x_r : '0;
    end
  end

  assign adv_o                 = adv;
  assign out_valid             = out_valid_r;
  assign out_alpha_kind        = out_kind_r;
  assign out_texel_total       = out_t_r;
  assign out_between_count     = out_b_r;
  assign out_transparent_count = out_x_r;

  `DXTAC_ASSERT_NOW(a_opaque_empty, out_valid_r && out_kind_r == dxtac_pkg::KIND_OPAQUE, out_b_r == '0 && out_x_r == '0, "Opaque result carries non-zero counts.")
  `DXTAC_ASSERT_NOW(a_counts_fit, out_valid_r, (TALLY_W+1)'(out_b_r) + (TALLY_W+1)'(out_x_r) <= (TALLY_W+1)'(out_t_r), "Class counts exceed the texel total.")
  `DXTAC_ASSERT_NEXT(a_tally_clear, adv && ctl_i.valid && ctl_i.last, tally_t_r == '0 && tally_b_r == '0 && tally_x_r == '0, "Tallies not cleared after the last block.")
  `DXTAC_ASSERT_NEXT(a_result_held, !adv, m2_v_r && $stable(m2_t_r), "Waiting result lost while the output was stalled.")

endmodule

// ----- rtl/core/dxt_alpha_classifier.sv -----
// Alpha classifier for DXT1, DXT3 and DXT5 surfaces.
// Usage:
//   Input channel (in_valid / in_stall / in_block_bytes): one beat per 4x4
//   block in raster order, carrying the first eight bytes of the block.
//   Result channel (out_valid / out_stall / out_*): one beat after the last
//   block of each surface, giving the alpha kind and the three counts.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data):
//   always ready; write only while no block is in flight.
// Timing:
//   One block is taken every cycle while in_stall is low. Sixteen lanes decode
//   the texels of a block side by side and a merging stage adds their flags to
//   the tallies. The result for the last block of a surface passes through the
//   pipeline registers p1, p2 and p3, then m1, m2 and the output register.
//   When the receiver stalls, the result waits in the output register and
//   blocks keep flowing; in_stall rises only when a second result reaches
//   the stage behind a stalled one, and falls in the same cycle as the
//   receiver takes the waiting beat.
// Reset: registers return to DXT1, 4 x 4 texels, edges 0 and 255, keyed at
//   five percent; the block position and tallies clear, no result is pending.
// Depends on dxtac_pkg, dxtac_palette, dxtac_lane and dxtac_merge.
module dxt_alpha_classifier #(
  parameter int MAX_DIM = dxtac_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dxtac_pkg::BLK_W-1:0]     in_block_bytes,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_alpha_kind,
  output logic [dxtac_pkg::TALLY_W-1:0]   out_texel_total,
  output logic [dxtac_pkg::TALLY_W-1:0]   out_between_count,
  output logic [dxtac_pkg::TALLY_W-1:0]   out_transparent_count,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dxtac_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [dxtac_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LANES     = dxtac_pkg::LANES;
  localparam int BLK_W     = dxtac_pkg::BLK_W;
  localparam int DIM_CFG_W = dxtac_pkg::DIM_CFG_W;
  localparam int PCT_W     = dxtac_pkg::PCT_W;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int NBLK      = (MAX_DIM + 3) / 4;
  localparam int COL_W     = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int EXT_W     = ((DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W) + 1;
  localparam int CMP_W     = ((COL_W + 2) > DIM_W) ? (COL_W + 2) : DIM_W;

  // Configuration registers.
  dxtac_pkg::fmt_t      fmt_r;
  logic [DIM_CFG_W-1:0] img_w_r, img_h_r;
  logic [7:0]           edge_low_r, edge_high_r;
  logic [PCT_W-1:0]     keyed_pct_r;

  logic                 accept, adv;
  logic [COL_W-1:0]     col_r, row_r;
  logic [EXT_W-1:0]     w_ext, h_ext;
  logic [DIM_W-1:0]     w_c, h_c;
  logic [COL_W:0]       bw, bh;
  logic                 row_end, last, sup;
  logic [3:0]           col_vis, row_vis;
  logic [LANES-1:0]     vis_nxt;

  logic                 p1_v_r, p1_sup_r, p1_last_r;
  dxtac_pkg::fmt_t      p1_fmt_r;
  logic [BLK_W-1:0]     p1_blk_r;
  logic [LANES-1:0]     p1_vis_r;

  logic                 p2_v_r, p2_sup_r, p2_last_r;
  dxtac_pkg::fmt_t      p2_fmt_r;
  logic [BLK_W-1:0]     p2_blk_r;
  logic [LANES-1:0]     p2_vis_r;
  logic                 c_gt;

  logic                 p3_v_r, p3_sup_r, p3_last_r;
  logic [LANES-1:0]     p3_vis_r, p3_trans_r, p3_betw_r;

  dxtac_pkg::alpha_t     pal [8];
  dxtac_pkg::lane_flags_t flags [LANES];
  logic [LANES-1:0]     trans_nxt, betw_nxt;
  dxtac_pkg::beat_ctl_t merge_ctl;

  assign cfg_ready = 1'b1;
  assign in_stall  = !adv;
  assign accept    = in_valid && adv;
  assign sup       = fmt_r != dxtac_pkg::FMT_NONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r       <= dxtac_pkg::FMT_DXT1;
      img_w_r     <= DIM_CFG_W'(4);
      img_h_r     <= DIM_CFG_W'(4);
      edge_low_r  <= 8'd0;
      edge_high_r <= 8'd255;
      keyed_pct_r <= PCT_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dxtac_pkg::REG_FORMAT:    fmt_r       <= dxtac_pkg::fmt_t'(cfg_data[1:0]);
        dxtac_pkg::REG_WIDTH:     img_w_r     <= cfg_data[DIM_CFG_W-1:0];
        dxtac_pkg::REG_HEIGHT:    img_h_r     <= cfg_data[DIM_CFG_W-1:0];
        dxtac_pkg::REG_EDGE_LOW:  edge_low_r  <= cfg_data[7:0];
        dxtac_pkg::REG_EDGE_HIGH: edge_high_r <= cfg_data[7:0];
        dxtac_pkg::REG_KEYED_PCT: keyed_pct_r <= cfg_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped surface size and block grid.
  always_comb begin
    w_ext = EXT_W'(img_w_r);
    h_ext = EXT_W'(img_h_r);
    if (w_ext == '0) begin
      w_c = DIM_W'(1);
    end else if (w_ext > EXT_W'(MAX_DIM)) begin
      w_c = DIM_W'(MAX_DIM);
    end else begin
      w_c = DIM_W'(w_ext);
    end
    if (h_ext == '0) begin
      h_c = DIM_W'(1);
    end else if (h_ext > EXT_W'(MAX_DIM)) begin
      h_c = DIM_W'(MAX_DIM);
    end else begin
      h_c = DIM_W'(h_ext);
    end
    bw = (COL_W+1)'(((DIM_W+1)'(w_c) + (DIM_W+1)'(3)) >> 2);
    bh = (COL_W+1)'(((DIM_W+1)'(h_c) + (DIM_W+1)'(3)) >> 2);
    row_end = ((COL_W+1)'(col_r) + (COL_W+1)'(1)) >= bw;
    last    = row_end && (((COL_W+1)'(row_r) + (COL_W+1)'(1)) >= bh);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      col_vis[i] = CMP_W'({col_r, 2'(i)}) < CMP_W'(w_c);
      row_vis[i] = CMP_W'({row_r, 2'(i)}) < CMP_W'(h_c);
    end
    for (int t = 0; t < LANES; t++) begin
      vis_nxt[t] = col_vis[t & 3] && row_vis[t >> 2] && sup;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      if (accept) begin
        if (last) begin
          col_r <= '0;
          row_r <= '0;
        end else if (row_end) begin
          col_r <= '0;
          row_r <= row_r + COL_W'(1);
        end else begin
          col_r <= col_r + COL_W'(1);
        end
      end
      if (adv) begin
        p1_v_r <= accept;
        p2_v_r <= p1_v_r;
        p3_v_r <= p2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_sup_r   <= sup;
      p1_last_r  <= last;
      p1_fmt_r   <= fmt_r;
      p1_blk_r   <= in_block_bytes;
      p1_vis_r   <= vis_nxt;
      p2_sup_r   <= p1_sup_r;
      p2_last_r  <= p1_last_r;
      p2_fmt_r   <= p1_fmt_r;
      p2_blk_r   <= p1_blk_r;
      p2_vis_r   <= p1_vis_r;
      p3_sup_r   <= p2_sup_r;
      p3_last_r  <= p2_last_r;
      p3_vis_r   <= p2_vis_r;
      p3_trans_r <= trans_nxt & p2_vis_r;
      p3_betw_r  <= betw_nxt & p2_vis_r;
    end
  end

  dxtac_palette u_palette (
    .clk    (clk),
    .en     (adv),
    .ends_i (in_block_bytes[15:0]),
    .pal_o  (pal)
  );

  assign c_gt = p2_blk_r[15:0] > p2_blk_r[31:16];

  for (genvar t = 0; t < LANES; t++) begin : g_lane
    dxtac_lane u_lane (
      .fmt_i       (p2_fmt_r),
      .code1_i     (p2_blk_r[32 + 2*t +: 2]),
      .code3_i     (p2_blk_r[4*t +: 4]),
      .code5_i     (p2_blk_r[16 + 3*t +: 3]),
      .c_gt_i      (c_gt),
      .pal_i       (pal),
      .edge_low_i  (edge_low_r),
      .edge_high_i (edge_high_r),
      .flags_o     (flags[t])
    );
    assign trans_nxt[t] = flags[t].trans;
    assign betw_nxt[t]  = flags[t].betw;
  end

  assign merge_ctl.valid = p3_v_r;
  assign merge_ctl.sup   = p3_sup_r;
  assign merge_ctl.last  = p3_last_r;

  dxtac_merge u_merge (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ctl_i                 (merge_ctl),
    .vis_i                 (p3_vis_r),
    .trans_i               (p3_trans_r),
    .betw_i                (p3_betw_r),
    .keyed_pct_i           (keyed_pct_r),
    .out_stall             (out_stall),
    .adv_o                 (adv),
    .out_valid             (out_valid),
    .out_alpha_kind        (out_alpha_kind),
    .out_texel_total       (out_texel_total),
    .out_between_count     (out_between_count),
    .out_transparent_count (out_transparent_count)
  );

endmodule
